>>> sv/sine_template_matched_filter_macros.svh
// Assertion macros for the sine template matched filter
`ifndef SINE_TEMPLATE_MATCHED_FILTER_MACROS_SVH
`define SINE_TEMPLATE_MATCHED_FILTER_MACROS_SVH

// same-cycle implication
`define STMF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define STMF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/stmf_pkg.sv
// Shared types, constants and sine table generator of the matched filter
package stmf_pkg;

	localparam int SAMPLES_DEFAULT = 1024;
	localparam int MAX_FREQ        = 64;
	localparam int SINE_LOG2       = 8;
	localparam int SINE_DEPTH      = 1 << SINE_LOG2;

	localparam int TIME_W    = 32;
	localparam int PHASE_W   = 20;
	localparam int AMP_W     = 24;
	localparam int SINE_W    = 16;
	localparam int SINE_MAG_W = 15;
	localparam int FREQ_W    = 6;
	localparam int FCOUNT_W  = 7;
	localparam int DT_W      = 32;
	localparam int DATA_W    = 32;
	localparam int AREA_W    = 48;
	localparam int PROD_W    = SINE_W + AMP_W;
	localparam int AREA_SHIFT = 28;
	localparam int REG_INDEX_W = 1;

	localparam logic [FCOUNT_W-1:0] FCOUNT_RESET = FCOUNT_W'(64);
	localparam logic [DT_W-1:0]     DT_RESET     = DT_W'(1048);
	localparam logic [AREA_W-1:0]   AREA_MAX     = {1'b0, {(AREA_W-1){1'b1}}};
	localparam logic [AREA_W-1:0]   AREA_MIN_MAG = {1'b1, {(AREA_W-1){1'b0}}};
	localparam longint AREA_HALF = longint'(1) <<< (AREA_SHIFT - 1);

	localparam longint Q30_ONE = 64'sd1073741824;
	localparam longint CO1 = 64'sd1686629713;
	localparam longint CO3 = -64'sd693598668;
	localparam longint CO5 = 64'sd85569306;
	localparam longint CO7 = -64'sd5026995;
	localparam longint CO9 = 64'sd172272;
	localparam longint Q15_HALF = 64'sd16384;
	localparam longint Q15_MAX  = 64'sd32767;

	typedef enum logic [REG_INDEX_W-1:0] {
		REG_FREQ_COUNT = 1'b0,
		REG_TIME_STEP  = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic [PHASE_W-1:0]      phase_time;
		logic signed [AMP_W-1:0] amplitude;
	} sample_word_t;

	// quarter-wave sine entry k of SINE_DEPTH, Q0.15, odd Taylor series to x^9
	function automatic logic [SINE_MAG_W-1:0] sine_entry(input int k);
		longint x;
		longint z;
		longint s;
		longint v;
		longint r;
		if (k >= SINE_DEPTH) begin
			return SINE_MAG_W'(Q15_MAX);
		end
		x = longint'(k) <<< (30 - SINE_LOG2);
		z = (x * x) / Q30_ONE;
		s = CO9;
		s = CO7 + (s * z) / Q30_ONE;
		s = CO5 + (s * z) / Q30_ONE;
		s = CO3 + (s * z) / Q30_ONE;
		s = CO1 + (s * z) / Q30_ONE;
		v = (s * x) / Q30_ONE;
		if (v < 0) begin
			v = 0;
		end
		r = (v + Q15_HALF) >>> 15;
		if (r > Q15_MAX) begin
			r = Q15_MAX;
		end
		return SINE_MAG_W'(r);
	endfunction

endpackage

>>> sv/stmf_if.sv
// Valid/ready channel interfaces for sample items and result items
interface stmf_sample_if;
	logic                                      valid;
	logic                                      ready;
	logic [stmf_pkg::TIME_W-1:0]               sample_time;
	logic signed [stmf_pkg::AMP_W-1:0]         sample_amplitude;
	logic                                      last_sample;

	modport source (output valid, sample_time, sample_amplitude, last_sample, input ready);
	modport sink (input valid, sample_time, sample_amplitude, last_sample, output ready);
endinterface

interface stmf_result_if;
	logic                                      valid;
	logic                                      ready;
	logic [stmf_pkg::FREQ_W-1:0]               trial_frequency;
	logic signed [stmf_pkg::AREA_W-1:0]        match_area;
	logic                                      last_result;

	modport source (output valid, trial_frequency, match_area, last_result, input ready);
	modport sink (input valid, trial_frequency, match_area, last_result, output ready);
endinterface

>>> sv/stmf_sample_mem.sv
// Sample record store: one write port, one registered read port
module stmf_sample_mem #(
	parameter int MAX_SAMPLES = stmf_pkg::SAMPLES_DEFAULT,
	localparam int ADDR_W = $clog2(MAX_SAMPLES)
) (
	input  logic                   clk,
	input  logic                   wr_en,
	input  logic [ADDR_W-1:0]      wr_addr,
	input  stmf_pkg::sample_word_t wr_word,
	input  logic                   rd_en,
	input  logic [ADDR_W-1:0]      rd_addr,
	output stmf_pkg::sample_word_t rd_word
);

	stmf_pkg::sample_word_t mem [MAX_SAMPLES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_word;
		end
		if (rd_en) begin
			rd_word <= mem[rd_addr];
		end
	end

endmodule

>>> sv/stmf_sine_lut.sv
// Phase product and quarter-wave sine lookup, two register stages
module stmf_sine_lut (
	input  logic                                clk,
	input  logic [stmf_pkg::FREQ_W-1:0]         freq,
	input  logic [stmf_pkg::PHASE_W-1:0]        phase_time,
	output logic signed [stmf_pkg::SINE_W-1:0]  sine_s3
);

	localparam int IDX_W = stmf_pkg::SINE_LOG2 + 2;
	localparam int M_W   = stmf_pkg::SINE_LOG2 + 1;
	localparam int PROD_W = stmf_pkg::FREQ_W + stmf_pkg::PHASE_W;

	logic [stmf_pkg::SINE_MAG_W-1:0] rom [stmf_pkg::SINE_DEPTH+1];

	for (genvar k = 0; k <= stmf_pkg::SINE_DEPTH; k++) begin : g_rom
		localparam logic [stmf_pkg::SINE_MAG_W-1:0] ENTRY = stmf_pkg::sine_entry(k);
		assign rom[k] = ENTRY;
	end

	logic [PROD_W-1:0]                 phase_full;
	logic [IDX_W-1:0]                  idx;
	logic [M_W-1:0]                    r_ext;
	logic [M_W-1:0]                    m_s2;
	logic                              neg_s2;
	logic [stmf_pkg::SINE_W-1:0]       sine_mag;

	always_comb begin
		phase_full = freq * phase_time;
		idx        = phase_full[stmf_pkg::PHASE_W-1 -: IDX_W];
		r_ext      = {1'b0, idx[stmf_pkg::SINE_LOG2-1:0]};
		sine_mag   = {1'b0, rom[m_s2]};
	end

	always_ff @(posedge clk) begin
		m_s2    <= idx[IDX_W-2] ? (M_W'(stmf_pkg::SINE_DEPTH) - r_ext) : r_ext;
		neg_s2  <= idx[IDX_W-1];
		sine_s3 <= neg_s2 ? -signed'(sine_mag) : signed'(sine_mag);
	end

endmodule

>>> sv/stmf_scaler.sv
// Area scaler: |sum| times time step in 32-bit chunks, round, saturate, sign
module stmf_scaler #(
	parameter int SUM_W = stmf_pkg::PROD_W + 11
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [SUM_W-1:0]            sum,
	input  logic [stmf_pkg::DT_W-1:0]          dt,
	output logic                               done,
	output logic signed [stmf_pkg::AREA_W-1:0] area
);

	localparam int CHUNK_W = stmf_pkg::DT_W;
	localparam int NCHUNK  = (SUM_W + CHUNK_W - 1) / CHUNK_W;
	localparam int PAD_W   = NCHUNK * CHUNK_W;
	localparam int ACC_W   = PAD_W + CHUNK_W;
	localparam int RND_W   = ACC_W + 1 - stmf_pkg::AREA_SHIFT;
	localparam int CNT_W   = $clog2(NCHUNK + 1);

	typedef enum logic [2:0] {IDLE, MUL, ADD, ROUND, SAT} state_t;

	state_t                         state_q;
	logic [CNT_W-1:0]               chunk_q;
	logic [PAD_W-1:0]               mag_q;
	logic [2*CHUNK_W-1:0]           prod_q;
	logic [ACC_W-1:0]               acc_q;
	logic [RND_W-1:0]               rnd_q;
	logic                           neg_q;
	logic [SUM_W-1:0]               mag_w;
	logic [RND_W-1:0]               lim_w;
	logic [stmf_pkg::AREA_W-1:0]    res_w;

	always_comb begin
		mag_w = sum[SUM_W-1] ? (~sum + SUM_W'(1)) : sum;
		lim_w = neg_q ? RND_W'(stmf_pkg::AREA_MIN_MAG) : RND_W'(stmf_pkg::AREA_MAX);
		res_w = (rnd_q > lim_w) ? lim_w[stmf_pkg::AREA_W-1:0] : rnd_q[stmf_pkg::AREA_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			chunk_q <= '0;
			mag_q   <= '0;
			prod_q  <= '0;
			acc_q   <= '0;
			rnd_q   <= '0;
			neg_q   <= 1'b0;
			done    <= 1'b0;
			area    <= '0;
		end else begin
			done <= state_q == SAT;
			case (state_q)
				IDLE: begin
					if (start) begin
						mag_q   <= PAD_W'(mag_w);
						neg_q   <= sum[SUM_W-1];
						acc_q   <= '0;
						chunk_q <= CNT_W'(NCHUNK);
						state_q <= MUL;
					end
				end
				MUL: begin
					prod_q  <= mag_q[PAD_W-1 -: CHUNK_W] * dt;
					mag_q   <= mag_q << CHUNK_W;
					state_q <= ADD;
				end
				ADD: begin
					acc_q   <= (acc_q << CHUNK_W) + ACC_W'(prod_q);
					chunk_q <= chunk_q - CNT_W'(1);
					state_q <= (chunk_q == CNT_W'(1)) ? ROUND : MUL;
				end
				ROUND: begin
					rnd_q   <= RND_W'(({1'b0, acc_q} + (ACC_W+1)'(stmf_pkg::AREA_HALF))
						>> stmf_pkg::AREA_SHIFT);
					state_q <= SAT;
				end
				SAT: begin
					area    <= neg_q ? -signed'(res_w) : signed'(res_w);
					state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

>>> sv/sine_template_matched_filter.sv
// Top level: record loader, frequency sequencer and shared multiply-accumulate
// Loading takes one sample item per cycle; a record holds up to MAX_SAMPLES samples.
// After the last sample, each trial frequency is computed by the one
// multiply-accumulate, which reads one stored sample a cycle.
// F results follow a record; no sample is taken meanwhile.
// Asynchronous active-low reset empties the record and restores both registers.
module sine_template_matched_filter #(
	parameter int MAX_SAMPLES = stmf_pkg::SAMPLES_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	stmf_sample_if.sink                          samples,
	stmf_result_if.source                        results,
	input  logic                                 write_enable,
	input  logic [stmf_pkg::REG_INDEX_W-1:0]     register_index,
	input  logic [stmf_pkg::DATA_W-1:0]          write_data
);

	`include "sine_template_matched_filter_macros.svh"

	localparam int ADDR_W = $clog2(MAX_SAMPLES);
	localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W  = stmf_pkg::PROD_W + CNT_W;

	typedef enum logic [2:0] {LOAD, ISSUE, DRAIN, SCALE, EMIT} state_t;

	state_t                                  state_q;
	logic [CNT_W-1:0]                        count_q;
	logic [stmf_pkg::FREQ_W-1:0]             freq_q;
	logic [stmf_pkg::FREQ_W-1:0]             f_last_q;
	logic [ADDR_W-1:0]                       rd_addr_q;
	logic                                    scale_start_q;
	logic                                    out_valid_q;
	logic [stmf_pkg::FREQ_W-1:0]             out_freq_q;
	logic signed [stmf_pkg::AREA_W-1:0]      out_area_q;
	logic                                    out_last_q;
	logic [stmf_pkg::FCOUNT_W-1:0]           fcount_q;
	logic [stmf_pkg::DT_W-1:0]               dt_q;

	logic                                    in_fire;
	logic                                    emit_fire;
	logic                                    have_room;
	logic [CNT_W-1:0]                        count_next;
	logic [CNT_W-1:0]                        count_less;
	logic [ADDR_W-1:0]                       last_idx;
	logic [stmf_pkg::FCOUNT_W-1:0]           fc_less;
	logic [stmf_pkg::FREQ_W-1:0]             f_last_w;
	logic                                    rd_en;
	logic                                    sum_clr;
	logic                                    pipe_busy;
	logic                                    scale_go;
	stmf_pkg::sample_word_t                  wr_word;
	stmf_pkg::sample_word_t                  rd_word;

	logic                                    v_s1, v_s2, v_s3, v_s4;
	logic                                    endpt_s1, endpt_s2, endpt_s3, endpt_s4;
	logic signed [stmf_pkg::AMP_W-1:0]       amp_s2, amp_s3;
	logic signed [stmf_pkg::SINE_W-1:0]      sine_s3;
	logic signed [stmf_pkg::PROD_W-1:0]      prod_s4;
	logic signed [SUM_W-1:0]                 sum_q;

	logic                                    scale_done;
	logic signed [stmf_pkg::AREA_W-1:0]      scale_area;

	always_comb begin
		in_fire    = samples.valid && samples.ready;
		emit_fire  = (state_q == EMIT) && (!out_valid_q || results.ready);
		have_room  = count_q < CNT_W'(MAX_SAMPLES);
		count_next = have_room ? (count_q + CNT_W'(1)) : count_q;
		count_less = count_q - CNT_W'(1);
		last_idx   = count_less[ADDR_W-1:0];
		fc_less    = fcount_q - stmf_pkg::FCOUNT_W'(1);
		if (fcount_q == '0) begin
			f_last_w = '0;
		end else if (fcount_q > stmf_pkg::FCOUNT_W'(stmf_pkg::MAX_FREQ)) begin
			f_last_w = stmf_pkg::FREQ_W'(stmf_pkg::MAX_FREQ - 1);
		end else begin
			f_last_w = fc_less[stmf_pkg::FREQ_W-1:0];
		end
		rd_en     = state_q == ISSUE;
		sum_clr   = (in_fire && samples.last_sample) || (emit_fire && (freq_q != f_last_q));
		pipe_busy = v_s1 || v_s2 || v_s3 || v_s4;
		scale_go  = (in_fire && samples.last_sample && (count_next < CNT_W'(2)))
			|| ((state_q == DRAIN) && !pipe_busy)
			|| (emit_fire && (freq_q != f_last_q) && (count_q < CNT_W'(2)));
		wr_word.phase_time = samples.sample_time[stmf_pkg::PHASE_W-1:0];
		wr_word.amplitude  = samples.sample_amplitude;
	end

	assign samples.ready           = state_q == LOAD;
	assign results.valid           = out_valid_q;
	assign results.trial_frequency = out_freq_q;
	assign results.match_area      = out_area_q;
	assign results.last_result     = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcount_q <= stmf_pkg::FCOUNT_RESET;
			dt_q     <= stmf_pkg::DT_RESET;
		end else if (write_enable) begin
			case (stmf_pkg::reg_index_t'(register_index))
				stmf_pkg::REG_FREQ_COUNT: fcount_q <= write_data[stmf_pkg::FCOUNT_W-1:0];
				stmf_pkg::REG_TIME_STEP:  dt_q <= write_data[stmf_pkg::DT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= LOAD;
			count_q       <= '0;
			freq_q        <= '0;
			f_last_q      <= '0;
			rd_addr_q     <= '0;
			scale_start_q <= 1'b0;
			out_valid_q   <= 1'b0;
			out_freq_q    <= '0;
			out_area_q    <= '0;
			out_last_q    <= 1'b0;
		end else begin
			scale_start_q <= scale_go;
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				LOAD: begin
					if (in_fire) begin
						count_q <= count_next;
						if (samples.last_sample) begin
							freq_q    <= '0;
							f_last_q  <= f_last_w;
							rd_addr_q <= '0;
							if (count_next >= CNT_W'(2)) begin
								state_q <= ISSUE;
							end else begin
								state_q <= SCALE;
							end
						end
					end
				end
				ISSUE: begin
					rd_addr_q <= rd_addr_q + ADDR_W'(1);
					if (rd_addr_q == last_idx) begin
						state_q <= DRAIN;
					end
				end
				DRAIN: begin
					if (!pipe_busy) begin
						state_q <= SCALE;
					end
				end
				SCALE: begin
					if (scale_done) begin
						state_q <= EMIT;
					end
				end
				EMIT: begin
					if (emit_fire) begin
						out_freq_q  <= freq_q;
						out_area_q  <= scale_area;
						out_last_q  <= freq_q == f_last_q;
						if (freq_q == f_last_q) begin
							state_q <= LOAD;
							count_q <= '0;
						end else begin
							freq_q    <= freq_q + stmf_pkg::FREQ_W'(1);
							rd_addr_q <= '0;
							if (count_q >= CNT_W'(2)) begin
								state_q <= ISSUE;
							end else begin
								state_q <= SCALE;
							end
						end
					end
				end
				default: state_q <= LOAD;
			endcase
		end
	end

	stmf_sample_mem #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_mem (
		.clk    (clk),
		.wr_en  (in_fire && have_room),
		.wr_addr(count_q[ADDR_W-1:0]),
		.wr_word(wr_word),
		.rd_en  (rd_en),
		.rd_addr(rd_addr_q),
		.rd_word(rd_word)
	);

	stmf_sine_lut u_sine (
		.clk       (clk),
		.freq      (freq_q),
		.phase_time(rd_word.phase_time),
		.sine_s3   (sine_s3)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			endpt_s1 <= 1'b0;
			endpt_s2 <= 1'b0;
			endpt_s3 <= 1'b0;
			endpt_s4 <= 1'b0;
		end else begin
			v_s1     <= rd_en;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			v_s4     <= v_s3;
			endpt_s1 <= (rd_addr_q == '0) || (rd_addr_q == last_idx);
			endpt_s2 <= endpt_s1;
			endpt_s3 <= endpt_s2;
			endpt_s4 <= endpt_s3;
		end
	end

	// end points of the record count once, inner samples twice
	always_ff @(posedge clk) begin
		amp_s2  <= rd_word.amplitude;
		amp_s3  <= amp_s2;
		prod_s4 <= sine_s3 * amp_s3;
		if (sum_clr) begin
			sum_q <= '0;
		end else if (v_s4) begin
			sum_q <= sum_q + (endpt_s4 ? SUM_W'(prod_s4) : (SUM_W'(prod_s4) <<< 1));
		end
	end

	stmf_scaler #(
		.SUM_W(SUM_W)
	) u_scaler (
		.clk   (clk),
		.arst_n(arst_n),
		.start (scale_start_q),
		.sum   (sum_q),
		.dt    (dt_q),
		.done  (scale_done),
		.area  (scale_area)
	);

	`STMF_ASSERT_SAME(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(MAX_SAMPLES), "sample count beyond store depth")
	`STMF_ASSERT_SAME(a_done_in_scale, clk, arst_n, scale_done, state_q == SCALE, "scaler finished outside scale phase")
	`STMF_ASSERT_NEXT(a_last_starts, clk, arst_n, in_fire && samples.last_sample, !samples.ready, "last sample did not start computation")

endmodule
